[design/abrl_pkg.sv]
// Package for the two-band audio level meter.
// Holds widths, configuration register indexes and the fixed FIR coefficients.
// No dependencies.
package abrl_pkg;

    // Field and datapath widths
    localparam int SAMPLE_BITS = 10;
    localparam int LOW_TAPS    = 20;
    localparam int MID_TAPS    = 23;
    localparam int FIR_CELLS   = (LOW_TAPS > MID_TAPS) ? LOW_TAPS : MID_TAPS;
    localparam int COEF_W      = 17;                       // signed Q.16
    localparam int COEF_FRAC   = 16;
    localparam int ACC_W       = COEF_W + SAMPLE_BITS + 1; // filter partial sums
    localparam int VAL_W       = ACC_W - COEF_FRAC;        // clamped filter value
    localparam int DC_W        = 10;
    localparam int GATE_W      = 12;
    localparam int GAIN_W      = 8;
    localparam int ATT_W       = 8;
    localparam int LEVEL_W     = 12;
    localparam int PROD_W      = VAL_W + GAIN_W;           // Q.4 band product
    localparam int LVL_W       = PROD_W - 4;               // band level before saturation
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DC_POINT          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_BAND_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_ATTENUATION = 3'd5;

    typedef logic        [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    // Coefficient tables, signed Q.16
    localparam int LOW_COEF_COUNT = 20;
    localparam int MID_COEF_COUNT = 23;

    localparam coef_t LOW_COEF_TABLE [LOW_COEF_COUNT] = '{
        17'sd390,  17'sd546,  17'sd974,  17'sd1666, 17'sd2570,
        17'sd3597, 17'sd4632, 17'sd5550, 17'sd6237, 17'sd6605,
        17'sd6605, 17'sd6237, 17'sd5550, 17'sd4632, 17'sd3597,
        17'sd2570, 17'sd1666, 17'sd974,  17'sd546,  17'sd390
    };

    localparam coef_t MID_COEF_TABLE [MID_COEF_COUNT] = '{
        -17'sd6,    -17'sd65,   -17'sd202,  -17'sd482,  -17'sd957,
        -17'sd1638, -17'sd2494, -17'sd3445, -17'sd4379, -17'sd5168,
        -17'sd5696, 17'sd59667,
        -17'sd5696, -17'sd5168, -17'sd4379, -17'sd3445, -17'sd2494,
        -17'sd1638, -17'sd957,  -17'sd482,  -17'sd202,  -17'sd65,
        -17'sd6
    };

    // Tap k of the low band; taps past the table or past the tap count are zero
    function automatic coef_t low_coef(input int k);
        coef_t c;
        c = '0;
        if (k < LOW_TAPS && k < LOW_COEF_COUNT)
        begin
            c = LOW_COEF_TABLE[k];
        end
        return c;
    endfunction

    // Tap k of the mid band
    function automatic coef_t mid_coef(input int k);
        coef_t c;
        c = '0;
        if (k < MID_TAPS && k < MID_COEF_COUNT)
        begin
            c = MID_COEF_TABLE[k];
        end
        return c;
    endfunction

endpackage

[design/audio_band_rgb_level.sv]
// Two-band audio level meter. Each sample beat runs through a 20-tap low-pass
// and a 23-tap band-pass FIR, each built as a row of transposed-form cells, then
// through rectification around dc_point, band gain, noise gate and cross
// attenuation of green by red. One sample beat is taken every cycle while no result
// waits on level_ready; a result beat passes the filter sum, band product, gated
// level, cross stage and output registers in turn. The whole pipeline, filter cells
// included, holds while a result waits on level_ready. Configuration writes
// land in the next cycle and must only happen with the pipeline empty.
// Depends on abrl_pkg, abrl_fir and abrl_band.
module audio_band_rgb_level
    import abrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                  level_valid,
    input  logic                  level_ready,
    output logic [LEVEL_W-1:0]    red_level,
    output logic [LEVEL_W-1:0]    green_level,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DC_W-1:0]   dc_point_reg;
    logic [GATE_W-1:0] squelch_reg;
    logic [GAIN_W-1:0] red_gain_reg;
    logic [GAIN_W-1:0] green_gain_reg;
    logic [GATE_W-1:0] cross_thr_reg;
    logic [ATT_W-1:0]  cross_att_reg;

    logic advance;
    logic accept;
    logic [3:0] stage_valid_reg;
    logic [3:0] stage_valid_next;
    logic       out_valid_reg;

    coef_t low_coefs [FIR_CELLS];
    coef_t mid_coefs [FIR_CELLS];
    acc_t  low_sum;
    acc_t  mid_sum;

    logic [LVL_W-1:0]       red_lvl;
    logic [LVL_W-1:0]       green_lvl;
    logic                   cross_hit;
    logic [LVL_W+ATT_W-1:0] green_prod_next;
    logic [LVL_W+ATT_W-1:0] green_prod_reg;
    logic [LEVEL_W-1:0]     red_sat_next;
    logic [LEVEL_W-1:0]     red_sat_reg;
    logic [LVL_W-1:0]       green_att;
    logic [LEVEL_W-1:0]     green_sat;
    logic [LEVEL_W-1:0]     red_out_reg;
    logic [LEVEL_W-1:0]     green_out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_point_reg   <= DC_W'(470);
            squelch_reg    <= '0;
            red_gain_reg   <= GAIN_W'(64);
            green_gain_reg <= GAIN_W'(32);
            cross_thr_reg  <= GATE_W'(200);
            cross_att_reg  <= ATT_W'(51);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DC_POINT:          dc_point_reg   <= cfg_data[DC_W-1:0];
                CFG_NOISE_GATE:        squelch_reg    <= cfg_data[GATE_W-1:0];
                CFG_LOW_BAND_GAIN:     red_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_MID_BAND_GAIN:     green_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_CROSS_THRESHOLD:   cross_thr_reg  <= cfg_data[GATE_W-1:0];
                CFG_CROSS_ATTENUATION: cross_att_reg  <= cfg_data[ATT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline moves whenever the output register is free or being drained
    assign advance      = !out_valid_reg || level_ready;
    assign accept       = sample_valid && advance;
    assign sample_ready = advance;

    assign stage_valid_next = {stage_valid_reg[2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= stage_valid_reg[3];
        end
    end

    // Fixed tap values per cell
    for (genvar k = 0; k < FIR_CELLS; k++)
    begin : g_coef
        assign low_coefs[k] = low_coef(k);
        assign mid_coefs[k] = mid_coef(k);
    end

    // Filters: cell rows advance only on accepted beats
    abrl_fir u_low_fir (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .x     (sample),
        .coefs (low_coefs),
        .sum   (low_sum)
    );

    abrl_fir u_mid_fir (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .x     (sample),
        .coefs (mid_coefs),
        .sum   (mid_sum)
    );

    // Band level paths
    abrl_band u_low_band (
        .clk      (clk),
        .en       (advance),
        .sum      (low_sum),
        .dc_point (dc_point_reg),
        .gain     (red_gain_reg),
        .squelch  (squelch_reg),
        .level    (red_lvl)
    );

    abrl_band u_mid_band (
        .clk      (clk),
        .en       (advance),
        .sum      (mid_sum),
        .dc_point (dc_point_reg),
        .gain     (green_gain_reg),
        .squelch  (squelch_reg),
        .level    (green_lvl)
    );

    // Cross stage: compare red before saturation, scale green in Q0.8
    assign cross_hit       = red_lvl > LVL_W'(cross_thr_reg);
    assign green_prod_next = cross_hit
                             ? (LVL_W+ATT_W)'(green_lvl) * (LVL_W+ATT_W)'(cross_att_reg)
                             : {green_lvl, {ATT_W{1'b0}}};
    assign red_sat_next    = (|red_lvl[LVL_W-1:LEVEL_W]) ? LEVEL_MAX
                                                         : red_lvl[LEVEL_W-1:0];

    // Output stage: drop the attenuation fraction and saturate green
    assign green_att = green_prod_reg[LVL_W+ATT_W-1:ATT_W];
    assign green_sat = (|green_att[LVL_W-1:LEVEL_W]) ? LEVEL_MAX
                                                     : green_att[LEVEL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            green_prod_reg <= green_prod_next;
            red_sat_reg    <= red_sat_next;
            red_out_reg    <= red_sat_reg;
            green_out_reg  <= green_sat;
        end
    end

    assign level_valid = out_valid_reg;
    assign red_level   = red_out_reg;
    assign green_level = green_out_reg;

endmodule

[design/abrl_fir_cell.sv]
// One cell of a transposed-form FIR: multiplies the sample by its tap and
// adds the partial sum handed over by its right neighbor. Depends on abrl_pkg.
module abrl_fir_cell
    import abrl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  sample_t x,
    input  coef_t   coef,
    input  acc_t    chain_in,
    output acc_t    chain_out
);

    acc_t partial_reg;
    acc_t partial_next;
    acc_t tap_prod;

    // Tap product; sample is unsigned, so extend with a zero sign bit
    assign tap_prod     = ACC_W'(coef) * ACC_W'($signed({1'b0, x}));
    assign partial_next = tap_prod + chain_in;

    // Partial sum register, zero after reset (empty delay line)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else if (en)
        begin
            partial_reg <= partial_next;
        end
    end

    assign chain_out = partial_reg;

endmodule

[design/abrl_fir.sv]
// Row of FIR cells for one band; cell 0 holds the finished filter sum.
// Depends on abrl_pkg and abrl_fir_cell.
module abrl_fir
    import abrl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  sample_t x,
    input  coef_t   coefs [FIR_CELLS],
    output acc_t    sum
);

    acc_t chain [FIR_CELLS+1];

    // Far end of the row feeds zero
    assign chain[FIR_CELLS] = '0;

    // Cells hand partial sums toward cell 0 on every accepted beat
    for (genvar k = 0; k < FIR_CELLS; k++)
    begin : g_cell
        abrl_fir_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .x         (x),
            .coef      (coefs[k]),
            .chain_in  (chain[k+1]),
            .chain_out (chain[k])
        );
    end

    assign sum = chain[0];

endmodule

[design/abrl_band.sv]
// Band level path: clamp and truncate the filter sum, rectify around the
// DC point, apply gain and noise gate. Two register stages. Depends on abrl_pkg.
module abrl_band
    import abrl_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  acc_t              sum,
    input  logic [DC_W-1:0]   dc_point,
    input  logic [GAIN_W-1:0] gain,
    input  logic [GATE_W-1:0] squelch,
    output logic [LVL_W-1:0]  level
);

    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  dc_ext;
    logic [VAL_W-1:0]  diff;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] gate_q4;
    logic [LVL_W-1:0]  level_next;
    logic [LVL_W-1:0]  level_reg;

    // Negative sums clamp to zero, otherwise drop the fraction
    assign value  = sum[ACC_W-1] ? '0 : VAL_W'(sum[ACC_W-1:COEF_FRAC]);
    assign dc_ext = VAL_W'(dc_point);
    assign diff   = (value >= dc_ext) ? (value - dc_ext) : (dc_ext - value);

    assign prod_next = PROD_W'(diff) * PROD_W'(gain);

    // Gate compares in Q.4, level drops the gain fraction
    assign gate_q4    = PROD_W'({squelch, 4'b0000});
    assign level_next = (prod_reg > gate_q4) ? prod_reg[PROD_W-1:4] : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[design/abrl_checker.sv]
// Port-level checks for the audio level meter, bound to the top level.
// Depends on abrl_pkg and audio_band_rgb_level.
module abrl_checker
    import abrl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_ready,
    input logic                   level_valid,
    input logic                   level_ready,
    input logic [LEVEL_W-1:0]     red_level,
    input logic [LEVEL_W-1:0]     green_level
);

    // A stalled result beat holds its value
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        level_valid && !level_ready |=>
            level_valid && $stable(red_level) && $stable(green_level)
    ) else $error("result beat changed while stalled");

    // With the output register empty the block is always ready for a sample
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !level_valid |-> sample_ready
    ) else $error("sample refused with empty output");

    // Input back-pressure only comes from a stalled result
    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sample_ready |-> level_valid && !level_ready
    ) else $error("sample refused without output stall");

    // No result is shown while in reset
    a_reset_quiet: assert property (
        @(posedge clk)
        !rst_n |-> !level_valid
    ) else $error("result valid during reset");

endmodule

bind audio_band_rgb_level abrl_checker u_abrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .level_valid  (level_valid),
    .level_ready  (level_ready),
    .red_level    (red_level),
    .green_level  (green_level)
);
